// File: sv/e2cdt_pkg.sv
// ---------------------------------------------------------------------------
// e2cdt_pkg - epoch to civil date/time shared definitions
// Constants, reciprocals and small helpers for the date/time conversion
// pipeline.
// ---------------------------------------------------------------------------
package e2cdt_pkg;

  // number of register stages in the conversion pipeline
  localparam int unsigned NumStg = 14;

  // t / 86400 is done as (t >> 7) / 675 with a floor reciprocal of 2^35 / 675
  localparam logic [25:0] DayRecip = 26'd50903316;
  localparam int unsigned DayRecipShift = 35;
  localparam logic [9:0]  DayRest = 10'd675;

  // day count offsets that select the era (4 or 5) and give the day of era
  localparam logic [15:0] Era5First = 16'd11017;
  localparam logic [17:0] Era5Sub = 18'd11017;
  localparam logic [17:0] Era4Add = 18'd135080;

  // exact reciprocals over the operand ranges used below
  localparam logic [16:0] HourRecip = 17'd74566;   // x / 3600, x < 86400
  localparam logic [16:0] Div1460Recip = 17'd91930; // x / 1460, shift 27
  localparam logic [17:0] Div365Recip = 18'd183860; // x / 365, shift 26
  localparam logic [12:0] MinRecip = 13'd4370;     // x / 60, shift 18
  localparam logic [12:0] Div153Recip = 13'd6854;  // x / 153, shift 20
  localparam logic [12:0] CentRecip = 13'd5243;    // x / 100, shift 19

  // day of era boundaries of the 100-year and 400-year corrections
  localparam logic [17:0] Doe100a = 18'd36524;
  localparam logic [17:0] Doe100b = 18'd73048;
  localparam logic [17:0] Doe100c = 18'd109572;
  localparam logic [17:0] Doe400 = 18'd146096;

  localparam logic [11:0] YearEra4 = 12'd1600;
  localparam logic [11:0] YearEra5 = 12'd2000;

  // time of day fields travelling down the pipeline
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [23:0] bcd;
  } tod_t;

  // date fields travelling down the pipeline
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  // two BCD digits of a value below 100
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [13:0] tp;
    logic [3:0]  tens;
    logic [6:0]  ones;
    tp   = 14'(v) * 14'd103;
    tens = tp[13:10];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // first day of each month in a year counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/epoch_to_civil_date_time.sv
// ---------------------------------------------------------------------------
// epoch_to_civil_date_time - Unix seconds to local civil date and time
// Throughput: one beat per cycle; each stage holds while the next is full,
// so bubbles close up and the input keeps taking beats during an output stall
// until all fourteen stages hold a beat.
// The depth is set by the chain of reciprocal multiplies of the date path.
// Reset clears every stage valid bit and sets the offset register to 0.
// ---------------------------------------------------------------------------
module epoch_to_civil_date_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  // offset register
  input  logic        cfg_we_i,
  input  logic [16:0] utc_offset_seconds_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [11:0] year_number_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [31:0] date_bcd_o,
  output logic [23:0] time_bcd_o
);
  import e2cdt_pkg::*;

  logic [16:0]        offset_q;
  logic [NumStg-1:0]  vld_q;
  logic [NumStg-1:0]  en;

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= utc_offset_seconds_i;
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---- stage registers ----
  logic [31:0] s1_t_q;
  logic [24:0] s2_x_q;
  logic [6:0]  s2_lo_q;
  logic [50:0] s2_p_q;
  logic [15:0] s3_q0_q;
  logic [10:0] s3_r0_q;
  logic [6:0]  s3_lo_q;
  logic [15:0] s4_day_q;
  logic [16:0] s4_sod_q;
  logic [17:0] s5_doe_q;
  logic        s5_era_q;
  logic [16:0] s5_sod_q;
  logic [33:0] s5_hp_q;
  logic [17:0] s6_doe_q;
  logic        s6_era_q;
  logic [34:0] s6_dq_q;
  logic [2:0]  s6_c36_q;
  logic        s6_c146_q;
  logic [4:0]  s6_hr_q;
  logic [11:0] s6_remh_q;
  logic [17:0] s7_n_q;
  logic [17:0] s7_doe_q;
  logic        s7_era_q;
  logic [4:0]  s7_hr_q;
  logic [11:0] s7_remh_q;
  logic [24:0] s7_mip_q;
  logic [35:0] s8_yp_q;
  logic [17:0] s8_doe_q;
  logic        s8_era_q;
  logic [4:0]  s8_hr_q;
  logic [5:0]  s8_mi_q;
  logic [5:0]  s8_se_q;
  logic [8:0]  s9_yoe_q;
  logic [8:0]  s9_doy_q;
  logic        s9_era_q;
  tod_t        s9_tod_q;
  logic [23:0] s10_mpp_q;
  logic [8:0]  s10_doy_q;
  logic [8:0]  s10_yoe_q;
  logic        s10_era_q;
  tod_t        s10_tod_q;
  date_t       s11_date_q;
  tod_t        s11_tod_q;
  logic [24:0] s12_cp_q;
  logic [15:0] s12_dm_q;
  date_t       s12_date_q;
  tod_t        s12_tod_q;
  logic [5:0]  s13_cen_q;
  logic [6:0]  s13_yy_q;
  logic [15:0] s13_dm_q;
  date_t       s13_date_q;
  tod_t        s13_tod_q;
  date_t       s14_date_q;
  tod_t        s14_tod_q;
  logic [31:0] s14_dbcd_q;

  // ---- next values ----
  logic [31:0] s1_t_d;
  logic [50:0] s2_p_d;
  logic [15:0] s3_q0_d;
  logic [25:0] s3_qm;
  logic [10:0] s3_r0_d;
  logic        s4_ge;
  logic [10:0] s4_r;
  logic [15:0] s4_day_d;
  logic [16:0] s4_sod_d;
  logic        s5_era_d;
  logic [17:0] s5_doe_d;
  logic [33:0] s5_hp_d;
  logic [34:0] s6_dq_d;
  logic [2:0]  s6_c36_d;
  logic [4:0]  s6_hr_d;
  logic [16:0] s6_hm;
  logic [11:0] s6_remh_d;
  logic [6:0]  s7_a;
  logic [17:0] s7_n_d;
  logic [24:0] s7_mip_d;
  logic [35:0] s8_yp_d;
  logic [5:0]  s8_mi_d;
  logic [11:0] s8_mm;
  logic [5:0]  s8_se_d;
  logic [8:0]  s9_yoe_d;
  logic [1:0]  s9_c100;
  logic [17:0] s9_base;
  logic [8:0]  s9_doy_d;
  tod_t        s9_tod_d;
  logic [10:0] s10_v;
  logic [23:0] s10_mpp_d;
  logic [3:0]  s11_mp;
  date_t       s11_date_d;
  logic [24:0] s12_cp_d;
  logic [15:0] s12_dm_d;
  logic [5:0]  s13_cen_d;
  logic [11:0] s13_cm;
  logic [6:0]  s13_yy_d;
  logic [31:0] s14_dbcd_d;

  always_comb begin
    // s1: apply the sign-extended offset, wrapping modulo 2^32
    s1_t_d = epoch_seconds_i + {{15{offset_q[16]}}, offset_q};

    // s2: reciprocal product for the day count
    s2_p_d = 51'(s1_t_q[31:7]) * 51'(DayRecip);

    // s3: day estimate and its remainder
    s3_q0_d = s2_p_q[DayRecipShift+15:DayRecipShift];
    s3_qm   = 26'(s3_q0_d) * 26'(DayRest);
    s3_r0_d = s2_x_q[10:0] - s3_qm[10:0];

    // s4: one correction step, seconds of day from remainder and low bits
    s4_ge    = s3_r0_q >= 11'(DayRest);
    s4_day_d = s3_q0_q + 16'(s4_ge);
    s4_r     = s4_ge ? s3_r0_q - 11'(DayRest) : s3_r0_q;
    s4_sod_d = {s4_r[9:0], s3_lo_q};

    // s5: era and day of era, hour reciprocal product
    s5_era_d = s4_day_q >= Era5First;
    s5_doe_d = s5_era_d ? 18'(s4_day_q) - Era5Sub : 18'(s4_day_q) + Era4Add;
    s5_hp_d  = 34'(s4_sod_q) * 34'(HourRecip);

    // s6: leap corrections of the era, hour and remaining seconds
    s6_dq_d   = 35'(s5_doe_q) * 35'(Div1460Recip);
    s6_c36_d  = 3'(s5_doe_q >= Doe100a) + 3'(s5_doe_q >= Doe100b)
              + 3'(s5_doe_q >= Doe100c) + 3'(s5_doe_q >= Doe400);
    s6_hr_d   = s5_hp_q[32:28];
    s6_hm     = 17'(s6_hr_d) * 17'd3600;
    s6_remh_d = 12'(s5_sod_q - s6_hm);

    // s7: day of era with leap days removed, minute reciprocal product
    s7_a     = s6_dq_q[33:27];
    s7_n_d   = s6_doe_q - 18'(s7_a) + 18'(s6_c36_q) - 18'(s6_c146_q);
    s7_mip_d = 25'(s6_remh_q) * 25'(MinRecip);

    // s8: year of era reciprocal product, minute and second
    s8_yp_d = 36'(s7_n_q) * 36'(Div365Recip);
    s8_mi_d = s7_mip_q[23:18];
    s8_mm   = 12'(s8_mi_d) * 12'd60;
    s8_se_d = 6'(s7_remh_q - s8_mm);

    // s9: year of era, day of year, time of day digits
    s9_yoe_d = s8_yp_q[34:26];
    s9_c100  = 2'(s9_yoe_d >= 9'd100) + 2'(s9_yoe_d >= 9'd200)
             + 2'(s9_yoe_d >= 9'd300);
    s9_base  = 18'(s9_yoe_d) * 18'd365 + 18'(s9_yoe_d[8:2]) - 18'(s9_c100);
    s9_doy_d = 9'(s8_doe_q - s9_base);
    s9_tod_d.hour   = s8_hr_q;
    s9_tod_d.minute = s8_mi_q;
    s9_tod_d.second = s8_se_q;
    s9_tod_d.bcd    = {bcd2(7'(s8_hr_q)), bcd2(7'(s8_mi_q)), bcd2(7'(s8_se_q))};

    // s10: month from March reciprocal product
    s10_v     = 11'(s9_doy_q) * 11'd5 + 11'd2;
    s10_mpp_d = 24'(s10_v) * 24'(Div153Recip);

    // s11: day, month and year, January and February belong to the next year
    s11_mp           = s10_mpp_q[23:20];
    s11_date_d.day   = 5'(s10_doy_q - month_start(s11_mp) + 9'd1);
    s11_date_d.month = (s11_mp < 4'd10) ? s11_mp + 4'd3 : s11_mp - 4'd9;
    s11_date_d.year  = 12'(s10_yoe_q) + (s10_era_q ? YearEra5 : YearEra4)
                     + 12'(s11_mp >= 4'd10);

    // s12: century reciprocal product, day and month digits
    s12_cp_d = 25'(s11_date_q.year) * 25'(CentRecip);
    s12_dm_d = {bcd2(7'(s11_date_q.day)), bcd2(7'(s11_date_q.month))};

    // s13: century and year within century
    s13_cen_d = s12_cp_q[24:19];
    s13_cm    = 12'(s13_cen_d) * 12'd100;
    s13_yy_d  = 7'(s12_date_q.year - s13_cm);

    // s14: packed date digits
    s14_dbcd_d = {s13_dm_q, bcd2(7'(s13_cen_q)), bcd2(s13_yy_q)};
  end

  // payload registers, each stage moves with its enable
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_t_q <= s1_t_d;
    end
    if (en[1]) begin
      s2_x_q  <= s1_t_q[31:7];
      s2_lo_q <= s1_t_q[6:0];
      s2_p_q  <= s2_p_d;
    end
    if (en[2]) begin
      s3_q0_q <= s3_q0_d;
      s3_r0_q <= s3_r0_d;
      s3_lo_q <= s2_lo_q;
    end
    if (en[3]) begin
      s4_day_q <= s4_day_d;
      s4_sod_q <= s4_sod_d;
    end
    if (en[4]) begin
      s5_doe_q <= s5_doe_d;
      s5_era_q <= s5_era_d;
      s5_sod_q <= s4_sod_q;
      s5_hp_q  <= s5_hp_d;
    end
    if (en[5]) begin
      s6_doe_q  <= s5_doe_q;
      s6_era_q  <= s5_era_q;
      s6_dq_q   <= s6_dq_d;
      s6_c36_q  <= s6_c36_d;
      s6_c146_q <= s5_doe_q >= Doe400;
      s6_hr_q   <= s6_hr_d;
      s6_remh_q <= s6_remh_d;
    end
    if (en[6]) begin
      s7_n_q    <= s7_n_d;
      s7_doe_q  <= s6_doe_q;
      s7_era_q  <= s6_era_q;
      s7_hr_q   <= s6_hr_q;
      s7_remh_q <= s6_remh_q;
      s7_mip_q  <= s7_mip_d;
    end
    if (en[7]) begin
      s8_yp_q  <= s8_yp_d;
      s8_doe_q <= s7_doe_q;
      s8_era_q <= s7_era_q;
      s8_hr_q  <= s7_hr_q;
      s8_mi_q  <= s8_mi_d;
      s8_se_q  <= s8_se_d;
    end
    if (en[8]) begin
      s9_yoe_q <= s9_yoe_d;
      s9_doy_q <= s9_doy_d;
      s9_era_q <= s8_era_q;
      s9_tod_q <= s9_tod_d;
    end
    if (en[9]) begin
      s10_mpp_q <= s10_mpp_d;
      s10_doy_q <= s9_doy_q;
      s10_yoe_q <= s9_yoe_q;
      s10_era_q <= s9_era_q;
      s10_tod_q <= s9_tod_q;
    end
    if (en[10]) begin
      s11_date_q <= s11_date_d;
      s11_tod_q  <= s10_tod_q;
    end
    if (en[11]) begin
      s12_cp_q   <= s12_cp_d;
      s12_dm_q   <= s12_dm_d;
      s12_date_q <= s11_date_q;
      s12_tod_q  <= s11_tod_q;
    end
    if (en[12]) begin
      s13_cen_q  <= s13_cen_d;
      s13_yy_q   <= s13_yy_d;
      s13_dm_q   <= s12_dm_q;
      s13_date_q <= s12_date_q;
      s13_tod_q  <= s12_tod_q;
    end
    if (en[13]) begin
      s14_date_q <= s13_date_q;
      s14_tod_q  <= s13_tod_q;
      s14_dbcd_q <= s14_dbcd_d;
    end
  end

  // output beat
  assign day_of_month_o     = s14_date_q.day;
  assign month_number_o     = s14_date_q.month;
  assign year_number_o      = s14_date_q.year;
  assign hour_of_day_o      = s14_tod_q.hour;
  assign minute_of_hour_o   = s14_tod_q.minute;
  assign second_of_minute_o = s14_tod_q.second;
  assign date_bcd_o         = s14_dbcd_q;
  assign time_bcd_o         = s14_tod_q.bcd;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for epoch_to_civil_date_time
// A table of directed timestamps and offsets, followed by phases of random
// timestamps under a range of time-zone offsets. Every output beat is compared
// field by field against a listed result or a behavioural date/time converter,
// with random idle gaps on the input and random back-pressure on the output.
// ---------------------------------------------------------------------------
module tb_top;

  // packed result of one conversion
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] date_bcd;
    logic [23:0] time_bcd;
  } civil_t;

  // one row of the directed table
  typedef struct packed {
    logic [16:0] offset;
    logic [31:0] epoch;
    logic        has_want;
    civil_t      want;
  } vector_t;

  localparam int unsigned DRAIN_CYCLES = e2cdt_pkg::NumStg + 4;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_BEATS  = 225;

  // offset settings, 17-bit two's complement
  localparam logic [16:0] OFF_ZERO      = 17'h00000;
  localparam logic [16:0] OFF_ONE       = 17'h00001;
  localparam logic [16:0] OFF_MINUS_ONE = 17'h1FFFF;
  localparam logic [16:0] OFF_WEST      = 17'h15740; // -43200
  localparam logic [16:0] OFF_EAST      = 17'h0C4E0; // +50400
  localparam logic [16:0] OFF_MOST_POS  = 17'h0FFFF;
  localparam logic [16:0] OFF_MOST_NEG  = 17'h10000;

  // first and last second a 32-bit count can reach, end of day one, a leap day
  localparam civil_t EPOCH_START = {5'd1, 4'd1, 12'd1970, 5'd0, 6'd0, 6'd0,
                                    32'h0101_1970, 24'h00_0000};
  localparam civil_t EPOCH_END   = {5'd7, 4'd2, 12'd2106, 5'd6, 6'd28, 6'd15,
                                    32'h0702_2106, 24'h06_2815};
  localparam civil_t DAY_ONE_END = {5'd1, 4'd1, 12'd1970, 5'd23, 6'd59, 6'd59,
                                    32'h0101_1970, 24'h23_5959};
  localparam civil_t LEAP_DAY    = {5'd29, 4'd2, 12'd2000, 5'd0, 6'd0, 6'd0,
                                    32'h2902_2000, 24'h00_0000};
  localparam civil_t NO_WANT     = '0;

  localparam int unsigned NUM_VECTORS = 24;
  localparam vector_t DIRECTED [NUM_VECTORS] = '{
    {OFF_ZERO,      32'h0000_0000, 1'b1, EPOCH_START},
    {OFF_ZERO,      32'd86399,     1'b1, DAY_ONE_END},
    {OFF_ZERO,      32'd86400,     1'b0, NO_WANT},
    {OFF_ZERO,      32'hFFFF_FFFF, 1'b1, EPOCH_END},
    {OFF_ZERO,      32'd951782400, 1'b1, LEAP_DAY},
    {OFF_ZERO,      32'd951868800, 1'b0, NO_WANT},
    {OFF_ZERO,      32'd946684799, 1'b0, NO_WANT},
    {OFF_ZERO,      32'h7FFF_FFFF, 1'b0, NO_WANT},
    {OFF_ZERO,      32'h8000_0000, 1'b0, NO_WANT},
    {OFF_ZERO,      32'hAAAA_AAAA, 1'b0, NO_WANT},
    {OFF_ZERO,      32'h5555_5555, 1'b0, NO_WANT},
    {OFF_ZERO,      32'd4107542399, 1'b0, NO_WANT},
    {OFF_ZERO,      32'd4107542400, 1'b0, NO_WANT},
    {OFF_MINUS_ONE, 32'h0000_0000, 1'b1, EPOCH_END},
    {OFF_MINUS_ONE, 32'h0001_0000, 1'b0, NO_WANT},
    {OFF_ONE,       32'hFFFF_FFFF, 1'b1, EPOCH_START},
    {OFF_WEST,      32'h0000_0000, 1'b0, NO_WANT},
    {OFF_WEST,      32'd43200,     1'b1, EPOCH_START},
    {OFF_EAST,      32'hFFFF_FFFF, 1'b0, NO_WANT},
    {OFF_EAST,      32'h0000_0000, 1'b0, NO_WANT},
    {OFF_MOST_POS,  32'hFFFF_0000, 1'b0, NO_WANT},
    {OFF_MOST_NEG,  32'h0000_FFFF, 1'b1, EPOCH_END},
    {OFF_MOST_NEG,  32'h0000_0000, 1'b0, NO_WANT},
    {OFF_ZERO,      32'd1234567890, 1'b0, NO_WANT}
  };

  logic        clk_i;
  logic        rst_ni               = 1'b0;
  logic        cfg_we_i             = 1'b0;
  logic [16:0] utc_offset_seconds_i = '0;
  logic        in_valid_i           = 1'b0;
  logic        in_ready_o;
  logic [31:0] epoch_seconds_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i          = 1'b0;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_number_o;
  logic [11:0] year_number_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;
  logic [31:0] date_bcd_o;
  logic [23:0] time_bcd_o;

  civil_t      pending_dates[$];
  logic [16:0] offset_shadow = '0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned stall_left    = 0;
  bit          sender_idle   = 1'b1;
  bit          sink_idle     = 1'b1;

  epoch_to_civil_date_time uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .utc_offset_seconds_i(utc_offset_seconds_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .epoch_seconds_i     (epoch_seconds_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .day_of_month_o      (day_of_month_o),
    .month_number_o      (month_number_o),
    .year_number_o       (year_number_o),
    .hour_of_day_o       (hour_of_day_o),
    .minute_of_hour_o    (minute_of_hour_o),
    .second_of_minute_o  (second_of_minute_o),
    .date_bcd_o          (date_bcd_o),
    .time_bcd_o          (time_bcd_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // two decimal digits of a value below 100
  function automatic logic [7:0] digit_pair(input logic [31:0] v);
    logic [31:0] tens;
    logic [31:0] ones;
    tens = (v / 32'd10) % 32'd10;
    ones = v % 32'd10;
    return {tens[3:0], ones[3:0]};
  endfunction

  // civil date and time of a local second count, era / day-of-era method
  function automatic civil_t civil_of(input logic [31:0] epoch, input logic [16:0] off);
    logic [31:0] t, z, era, doe, yoe, yr, doy, mp, day, mon, sod, hr, mi, se;
    civil_t      c;
    t   = epoch + {{15{off[16]}}, off};
    z   = t / 32'd86400 + 32'd719468;
    era = z / 32'd146097;
    doe = z - era * 32'd146097;
    yoe = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
    yr  = yoe + era * 32'd400;
    doy = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
    mp  = (32'd5 * doy + 32'd2) / 32'd153;
    day = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
    mon = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
    if (mon <= 32'd2) yr = yr + 32'd1;
    sod = t % 32'd86400;
    hr  = sod / 32'd3600;
    mi  = (t % 32'd3600) / 32'd60;
    se  = t % 32'd60;
    c.day      = day[4:0];
    c.month    = mon[3:0];
    c.year     = yr[11:0];
    c.hour     = hr[4:0];
    c.minute   = mi[5:0];
    c.second   = se[5:0];
    c.date_bcd = {digit_pair(day), digit_pair(mon), digit_pair(yr / 32'd100),
                  digit_pair(yr % 32'd100)};
    c.time_bcd = {digit_pair(hr), digit_pair(mi), digit_pair(se)};
    return c;
  endfunction

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random timestamp, weighted towards the wrap points and local midnight
  function automatic logic [31:0] pick_epoch(input logic [16:0] off);
    int unsigned r;
    logic [31:0] e;
    r = $urandom_range(0, 99);
    if (r < 45)
      e = $urandom();
    else if (r < 60)
      e = $urandom_range(0, 400000);
    else if (r < 75)
      e = 32'hFFFF_FFFF - $urandom_range(0, 400000);
    else
      e = 32'($urandom_range(0, 49710)) * 32'd86400 + 32'($urandom_range(0, 2))
          - 32'd1 - {{15{off[16]}}, off};
    return e;
  endfunction

  // one input beat, followed by an optional idle gap
  task automatic send_epoch(input logic [31:0] epoch, input civil_t want);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= epoch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_dates.push_back(want);
    gap = sender_idle ? pause_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and let every outstanding beat come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // offset register write, only with the pipeline empty
  task automatic load_offset(input logic [16:0] off);
    drain();
    cfg_we_i             <= 1'b1;
    utc_offset_seconds_i <= off;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    offset_shadow  = off;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // output back-pressure
  always @(posedge clk_i) begin
    if (stall_left == 0 && sink_idle) stall_left = pause_len();
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each output beat with the oldest expected date
  always @(posedge clk_i) begin : result_check
    civil_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        $error("output beat with no conversion outstanding");
        mismatch_cnt++;
      end else begin
        want = pending_dates.pop_front();
        check_field("day_of_month", 32'(want.day), 32'(day_of_month_o));
        check_field("month_number", 32'(want.month), 32'(month_number_o));
        check_field("year_number", 32'(want.year), 32'(year_number_o));
        check_field("hour_of_day", 32'(want.hour), 32'(hour_of_day_o));
        check_field("minute_of_hour", 32'(want.minute), 32'(minute_of_hour_o));
        check_field("second_of_minute", 32'(want.second), 32'(second_of_minute_o));
        check_field("date_bcd", want.date_bcd, date_bcd_o);
        check_field("time_bcd", 32'(want.time_bcd), 32'(time_bcd_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("epoch_to_civil_date_time test failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [16:0] off;
    logic [31:0] epoch;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_offset(OFF_ZERO);

    // directed table
    for (int i = 0; i < NUM_VECTORS; i++) begin
      if (DIRECTED[i].offset != offset_shadow) load_offset(DIRECTED[i].offset);
      send_epoch(DIRECTED[i].epoch,
                 DIRECTED[i].has_want ? DIRECTED[i].want
                                      : civil_of(DIRECTED[i].epoch, offset_shadow));
    end

    // random phases, one offset setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       off = OFF_ZERO;
        1:       off = OFF_WEST;
        3:       off = OFF_EAST;
        4:       off = OFF_MOST_POS;
        5:       off = OFF_MOST_NEG;
        6:       off = 17'($urandom_range(0, 131071));
        default: off = 17'($urandom_range(0, 93600)) - 17'd43200;
      endcase
      load_offset(off);
      sender_idle = (ph % 3) != 1;
      sink_idle   = (ph % 4) != 2;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // occasional hold-off until the pipeline has emptied
        if ($urandom_range(0, 149) == 0) drain();
        epoch = pick_epoch(offset_shadow);
        send_epoch(epoch, civil_of(epoch, offset_shadow));
      end
    end

    drain();
    if (mismatch_cnt == 0)
      $display("epoch_to_civil_date_time test passed");
    else
      $display("epoch_to_civil_date_time test failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/e2cdt_pkg.sv
sv/epoch_to_civil_date_time.sv
sim/tb_top.sv
